// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define NMS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define NMS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/nms_pkg.sv =====
`timescale 1ns / 1ps

package nms_pkg;

    localparam int BAND_COUNT_DEF  = 7;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int UNIFORM_W     = 16;
    localparam int UNIFORM_N     = 8;
    localparam int PINK_SRC_N    = 7;
    localparam int OUT_W         = 16;
    localparam int GAIN_W        = 16;
    localparam int PERIOD_W      = 16;
    localparam int MODE_W        = 3;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;
    localparam int COEF_W        = 15;
    localparam int BROWN_COEF_W  = 12;
    localparam int BROWN_SHIFT   = 16;
    localparam int CRACKLE_SHIFT = 15;
    localparam int GAIN_SHIFT    = 15;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [BROWN_COEF_W-1:0] COEF_BROWN = 12'd1311;
    localparam logic [COEF_W-1:0]       COEF_LOUD  = 15'd26214;
    localparam logic [COEF_W-1:0]       COEF_LIGHT = 15'd9830;
    localparam logic [COEF_W-1:0]       COEF_QUIET = 15'd328;
    localparam logic [UNIFORM_W-1:0]    THR_LOUD   = 16'd65340;
    localparam logic [UNIFORM_W-1:0]    THR_LIGHT  = 16'd64881;

    localparam logic [MODE_W-1:0] MODE_WHITE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PINK    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BROWN   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CRACKLE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HOLD    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_GEN_ON = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 4'd3;

    localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd32768;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd12;

    typedef enum logic [2:0] {
        OP_ZERO,
        OP_WHITE,
        OP_PINK,
        OP_BROWN,
        OP_CRACKLE,
        OP_HOLD
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PART,
        B_TOTAL,
        B_MUL,
        B_FIX,
        B_STEP2,
        B_GAIN,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic                gen_on;
        logic [MODE_W-1:0]   mode;
        logic [GAIN_W-1:0]   gain;
        logic [PERIOD_W-1:0] period;
    } cfg_t;

endpackage

// ===== src/multi_mode_noise_source_top.sv =====
`timescale 1ns / 1ps

// Noise source: each input word carries eight uniform random values and yields one
// signed Q1.15 sample, scaled by cfg.gain, in one of five modes (white, pink,
// brown, crackle, sample-and-hold); when gen_on is 0 or the mode code is unused
// the sample is zero and no internal state moves. The front end classifies and
// whitens each word and parks it in a two-entry queue; a single back-end
// sequencer then works on one word at a time, so throughput is set by that
// sequencer: white, zero and hold words go straight to the gain multiply and
// output stage; brown and crackle pass a second step first, and pink passes band
// update, two-level adder tree, reciprocal multiply and correction first. Results
// sit in an output register, so new words keep entering the queue while a result
// waits. Configuration is accepted every cycle and must only change while idle.
module multi_mode_noise_source_top #(
    parameter int BAND_COUNT  = nms_pkg::BAND_COUNT_DEF,
    parameter int SAMPLE_BITS = nms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [nms_pkg::UNIFORM_W-1:0]     s_uniform_0,
    input  logic [nms_pkg::UNIFORM_W-1:0]     s_uniform_1,
    input  logic [nms_pkg::UNIFORM_W-1:0]     s_uniform_2,
    input  logic [nms_pkg::UNIFORM_W-1:0]     s_uniform_3,
    input  logic [nms_pkg::UNIFORM_W-1:0]     s_uniform_4,
    input  logic [nms_pkg::UNIFORM_W-1:0]     s_uniform_5,
    input  logic [nms_pkg::UNIFORM_W-1:0]     s_uniform_6,
    input  logic [nms_pkg::UNIFORM_W-1:0]     s_uniform_7,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [nms_pkg::OUT_W-1:0]  m_noise_out,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nms_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int QW = $bits(nms_pkg::op_t) + nms_pkg::COEF_W
                        + nms_pkg::UNIFORM_N * SAMPLE_BITS;

    nms_pkg::cfg_t  cfg_reg, cfg_next;
    logic           q_push, q_full, q_pop, q_valid;
    logic [QW-1:0]  q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                nms_pkg::CFG_GEN_ON: cfg_next.gen_on = cfg_data[0];
                nms_pkg::CFG_MODE:   cfg_next.mode   = cfg_data[nms_pkg::MODE_W-1:0];
                nms_pkg::CFG_GAIN:   cfg_next.gain   = cfg_data[nms_pkg::GAIN_W-1:0];
                nms_pkg::CFG_PERIOD: cfg_next.period = cfg_data[nms_pkg::PERIOD_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gen_on <= 1'b0;
            cfg_reg.mode   <= nms_pkg::MODE_WHITE;
            cfg_reg.gain   <= nms_pkg::GAIN_RST;
            cfg_reg.period <= nms_pkg::PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    nms_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .QW          (QW)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_uniform_0 (s_uniform_0),
        .s_uniform_1 (s_uniform_1),
        .s_uniform_2 (s_uniform_2),
        .s_uniform_3 (s_uniform_3),
        .s_uniform_4 (s_uniform_4),
        .s_uniform_5 (s_uniform_5),
        .s_uniform_6 (s_uniform_6),
        .s_uniform_7 (s_uniform_7),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    nms_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_rdata)
    );

    nms_back #(
        .BAND_COUNT  (BAND_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .QW          (QW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_noise_out (m_noise_out)
    );

endmodule

// ===== src/nms_front.sv =====
`timescale 1ns / 1ps

module nms_front #(
    parameter int SAMPLE_BITS = nms_pkg::SAMPLE_BITS_DEF,
    parameter int QW          = $bits(nms_pkg::op_t) + nms_pkg::COEF_W
                                + nms_pkg::UNIFORM_N * SAMPLE_BITS
) (
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [nms_pkg::UNIFORM_W-1:0]   s_uniform_0,
    input  logic [nms_pkg::UNIFORM_W-1:0]   s_uniform_1,
    input  logic [nms_pkg::UNIFORM_W-1:0]   s_uniform_2,
    input  logic [nms_pkg::UNIFORM_W-1:0]   s_uniform_3,
    input  logic [nms_pkg::UNIFORM_W-1:0]   s_uniform_4,
    input  logic [nms_pkg::UNIFORM_W-1:0]   s_uniform_5,
    input  logic [nms_pkg::UNIFORM_W-1:0]   s_uniform_6,
    input  logic [nms_pkg::UNIFORM_W-1:0]   s_uniform_7,
    input  nms_pkg::cfg_t                   cfg,
    input  logic                            q_full,
    output logic                            q_push,
    output logic [QW-1:0]                   q_data
);

    localparam int OPW = $bits(nms_pkg::op_t);
    localparam int UW  = nms_pkg::UNIFORM_W;
    localparam int UP  = (SAMPLE_BITS > UW) ? SAMPLE_BITS - UW : 0;
    localparam int DN  = (SAMPLE_BITS < UW) ? UW - SAMPLE_BITS : 0;

    logic [UW-1:0]                  uni [nms_pkg::UNIFORM_N];
    logic signed [SAMPLE_BITS-1:0]  white [nms_pkg::UNIFORM_N];
    nms_pkg::op_t                   op;
    logic [nms_pkg::COEF_W-1:0]     coef;

    assign uni[0] = s_uniform_0;
    assign uni[1] = s_uniform_1;
    assign uni[2] = s_uniform_2;
    assign uni[3] = s_uniform_3;
    assign uni[4] = s_uniform_4;
    assign uni[5] = s_uniform_5;
    assign uni[6] = s_uniform_6;
    assign uni[7] = s_uniform_7;

    // centre each word on zero and bring it to the sample format
    for (genvar i = 0; i < nms_pkg::UNIFORM_N; i++) begin : g_white
        logic signed [UW-1:0]         centred;
        logic signed [UW+UP-1:0]      widened;
        assign centred = {~uni[i][UW-1], uni[i][UW-2:0]};
        assign widened = (UW + UP)'(centred) <<< UP;
        assign white[i] = SAMPLE_BITS'(widened >>> DN);
        assign q_data[OPW + nms_pkg::COEF_W + i*SAMPLE_BITS +: SAMPLE_BITS] = white[i];
    end

    always_comb begin
        op = nms_pkg::OP_ZERO;
        if (cfg.gen_on) begin
            case (cfg.mode)
                nms_pkg::MODE_WHITE:   op = nms_pkg::OP_WHITE;
                nms_pkg::MODE_PINK:    op = nms_pkg::OP_PINK;
                nms_pkg::MODE_BROWN:   op = nms_pkg::OP_BROWN;
                nms_pkg::MODE_CRACKLE: op = nms_pkg::OP_CRACKLE;
                nms_pkg::MODE_HOLD:    op = nms_pkg::OP_HOLD;
                default:               op = nms_pkg::OP_ZERO;
            endcase
        end
    end

    // crackle amplitude from the selector word
    always_comb begin
        if (s_uniform_0 >= nms_pkg::THR_LOUD) begin
            coef = nms_pkg::COEF_LOUD;
        end else if (s_uniform_0 >= nms_pkg::THR_LIGHT) begin
            coef = nms_pkg::COEF_LIGHT;
        end else begin
            coef = nms_pkg::COEF_QUIET;
        end
    end

    assign q_data[OPW-1:0]                   = op;
    assign q_data[OPW +: nms_pkg::COEF_W]    = coef;
    assign s_ready                           = !q_full;
    assign q_push                            = s_valid && !q_full;

endmodule

// ===== src/nms_queue.sv =====
`timescale 1ns / 1ps

module nms_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = nms_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/nms_back.sv =====
`timescale 1ns / 1ps

module nms_back #(
    parameter int BAND_COUNT  = nms_pkg::BAND_COUNT_DEF,
    parameter int SAMPLE_BITS = nms_pkg::SAMPLE_BITS_DEF,
    parameter int QW          = $bits(nms_pkg::op_t) + nms_pkg::COEF_W
                                + nms_pkg::UNIFORM_N * SAMPLE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  nms_pkg::cfg_t                      cfg,
    input  logic                               q_valid,
    input  logic [QW-1:0]                      q_data,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [nms_pkg::OUT_W-1:0]   m_noise_out
);

    localparam int SB      = SAMPLE_BITS;
    localparam int OPW     = $bits(nms_pkg::op_t);
    localparam int CW      = nms_pkg::COEF_W;
    localparam int OW      = nms_pkg::OUT_W;
    localparam int DIV     = BAND_COUNT + 1;
    localparam int SUM_W   = SB + $clog2(DIV);
    localparam int MUL_W   = 2 * SUM_W;
    localparam int Q_W     = SB + 1;
    localparam int R_W     = SUM_W + 2;
    localparam int GROUP_N = (DIV + 3) / 4;
    localparam int TERM_N  = GROUP_N * 4;
    localparam int PROD_W  = SB + nms_pkg::GAIN_W + 1;
    localparam int WALK_W  = SB + 2;
    localparam int UP      = (SB < OW) ? OW - SB : 0;
    localparam int DN      = (SB > OW) ? SB - OW : 0;
    localparam int PW      = nms_pkg::PERIOD_W;

    localparam longint unsigned RECIP = ((64'd1 << SUM_W) / DIV) + 64'd1;
    localparam logic [SUM_W-1:0] RECIP_C = SUM_W'(RECIP);
    localparam logic [SUM_W-1:0] OFS_C   = SUM_W'(longint'(DIV) << (SB - 1));
    localparam logic [R_W-1:0]   DIV_C   = R_W'(DIV);

    localparam logic signed [WALK_W-1:0] WALK_MAX = WALK_W'((longint'(1) << (SB - 1)) - 1);
    localparam logic signed [WALK_W-1:0] WALK_MIN = WALK_W'(-(longint'(1) << (SB - 1)));
    localparam logic signed [PROD_W-1:0] PROD_MAX = PROD_W'((longint'(1) << (SB - 1)) - 1);
    localparam logic signed [PROD_W-1:0] PROD_MIN = PROD_W'(-(longint'(1) << (SB - 1)));

    // queue word fields
    nms_pkg::op_t               q_op;
    logic [CW-1:0]              q_coef;
    logic signed [SB-1:0]       q_white [nms_pkg::UNIFORM_N];

    assign q_op   = nms_pkg::op_t'(q_data[OPW-1:0]);
    assign q_coef = q_data[OPW +: CW];
    for (genvar i = 0; i < nms_pkg::UNIFORM_N; i++) begin : g_unpack
        assign q_white[i] = q_data[OPW + CW + i*SB +: SB];
    end

    nms_pkg::back_state_t       state_reg, state_next;
    nms_pkg::op_t               op_reg, op_next;
    logic signed [SB-1:0]       band_reg [BAND_COUNT];
    logic signed [SB-1:0]       band_next [BAND_COUNT];
    logic [BAND_COUNT-1:0]      cnt_reg, cnt_next;
    logic signed [SB-1:0]       walk_reg, walk_next;
    logic signed [SB-1:0]       held_reg, held_next;
    logic [PW-1:0]              hold_cnt_reg, hold_cnt_next;
    logic                       out_valid_reg, out_valid_next;

    logic signed [SB-1:0]       w0_reg, w0_next;
    logic signed [SUM_W-1:0]    part_reg [GROUP_N];
    logic signed [SUM_W-1:0]    part_next [GROUP_N];
    logic [SUM_W-1:0]           ofs_reg, ofs_next;
    logic [MUL_W-1:0]           mul_reg, mul_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SB-1:0]       sample_reg, sample_next;
    logic signed [OW-1:0]       out_data_reg, out_data_next;

    // pink datapath
    logic [BAND_COUNT-1:0]      cnt_inc, flips;
    logic signed [SB-1:0]       term [TERM_N];
    logic signed [SUM_W-1:0]    part_sum [GROUP_N];
    logic signed [SUM_W-1:0]    total_sum;
    logic [Q_W-1:0]             q_est, q_fix;
    logic signed [R_W-1:0]      rem;
    logic signed [SB-1:0]       pink_sample;

    // brown, crackle, hold and gain
    logic signed [WALK_W-1:0]   walk_sum;
    logic signed [SB-1:0]       walk_clamped;
    logic signed [SB-1:0]       crackle_sample;
    logic [PW-1:0]              hold_inc;
    logic signed [PROD_W-1:0]   gain_shifted;
    logic signed [SB-1:0]       gain_clamped;
    logic signed [SB+UP-1:0]    out_widened;
    logic signed [OW-1:0]       out_scaled;

    assign cnt_inc = cnt_reg + 1'b1;
    assign flips   = cnt_reg ^ cnt_inc;

    always_comb begin
        for (int t = 0; t < TERM_N; t++) begin
            term[t] = '0;
        end
        term[0] = w0_reg;
        for (int b = 0; b < BAND_COUNT; b++) begin
            term[b + 1] = band_reg[b];
        end
    end

    for (genvar g = 0; g < GROUP_N; g++) begin : g_part
        assign part_sum[g] = SUM_W'(term[4*g]) + SUM_W'(term[4*g + 1])
                           + SUM_W'(term[4*g + 2]) + SUM_W'(term[4*g + 3]);
    end

    always_comb begin
        total_sum = '0;
        for (int g = 0; g < GROUP_N; g++) begin
            total_sum = total_sum + part_reg[g];
        end
    end

    // quotient estimate is exact or one too high
    assign q_est       = mul_reg[SUM_W +: Q_W];
    assign rem         = $signed(R_W'(ofs_reg)) - $signed(R_W'(q_est) * DIV_C);
    assign q_fix       = rem[R_W-1] ? q_est - 1'b1 : q_est;
    assign pink_sample = {~q_fix[SB-1], q_fix[SB-2:0]};

    assign walk_sum = WALK_W'(walk_reg) + WALK_W'(prod_reg >>> nms_pkg::BROWN_SHIFT);
    always_comb begin
        if (walk_sum > WALK_MAX) begin
            walk_clamped = SB'(WALK_MAX);
        end else if (walk_sum < WALK_MIN) begin
            walk_clamped = SB'(WALK_MIN);
        end else begin
            walk_clamped = SB'(walk_sum);
        end
    end

    assign crackle_sample = SB'(prod_reg >>> nms_pkg::CRACKLE_SHIFT);
    assign hold_inc       = hold_cnt_reg + 1'b1;

    assign gain_shifted = prod_reg >>> nms_pkg::GAIN_SHIFT;
    always_comb begin
        if (gain_shifted > PROD_MAX) begin
            gain_clamped = SB'(PROD_MAX);
        end else if (gain_shifted < PROD_MIN) begin
            gain_clamped = SB'(PROD_MIN);
        end else begin
            gain_clamped = SB'(gain_shifted);
        end
    end
    assign out_widened = (SB + UP)'(gain_clamped) <<< UP;
    assign out_scaled  = OW'(out_widened >>> DN);

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        band_next      = band_reg;
        cnt_next       = cnt_reg;
        walk_next      = walk_reg;
        held_next      = held_reg;
        hold_cnt_next  = hold_cnt_reg;
        w0_next        = w0_reg;
        part_next      = part_reg;
        ofs_next       = ofs_reg;
        mul_next       = mul_reg;
        prod_next      = prod_reg;
        sample_next    = sample_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_ready;
        q_pop          = 1'b0;

        case (state_reg)
            nms_pkg::B_IDLE: begin
                if (q_valid) begin
                    q_pop   = 1'b1;
                    op_next = q_op;
                    case (q_op)
                        nms_pkg::OP_WHITE: begin
                            sample_next = q_white[0];
                            state_next  = nms_pkg::B_GAIN;
                        end
                        nms_pkg::OP_PINK: begin
                            cnt_next = cnt_inc;
                            for (int b = 0; b < BAND_COUNT; b++) begin
                                if (flips[b]) begin
                                    band_next[b] = q_white[1 + (b % nms_pkg::PINK_SRC_N)];
                                end
                            end
                            w0_next    = q_white[0];
                            state_next = nms_pkg::B_PART;
                        end
                        nms_pkg::OP_BROWN: begin
                            prod_next  = PROD_W'(q_white[0])
                                       * $signed(PROD_W'(nms_pkg::COEF_BROWN));
                            state_next = nms_pkg::B_STEP2;
                        end
                        nms_pkg::OP_CRACKLE: begin
                            prod_next  = PROD_W'(q_white[1]) * $signed(PROD_W'(q_coef));
                            state_next = nms_pkg::B_STEP2;
                        end
                        nms_pkg::OP_HOLD: begin
                            if (hold_inc >= cfg.period) begin
                                hold_cnt_next = '0;
                                held_next     = q_white[0];
                                sample_next   = q_white[0];
                            end else begin
                                hold_cnt_next = hold_inc;
                                sample_next   = held_reg;
                            end
                            state_next = nms_pkg::B_GAIN;
                        end
                        default: begin
                            sample_next = '0;
                            state_next  = nms_pkg::B_GAIN;
                        end
                    endcase
                end
            end
            nms_pkg::B_PART: begin
                part_next  = part_sum;
                state_next = nms_pkg::B_TOTAL;
            end
            nms_pkg::B_TOTAL: begin
                ofs_next   = $unsigned(total_sum) + OFS_C;
                state_next = nms_pkg::B_MUL;
            end
            nms_pkg::B_MUL: begin
                mul_next   = MUL_W'(ofs_reg) * MUL_W'(RECIP_C);
                state_next = nms_pkg::B_FIX;
            end
            nms_pkg::B_FIX: begin
                sample_next = pink_sample;
                state_next  = nms_pkg::B_GAIN;
            end
            nms_pkg::B_STEP2: begin
                if (op_reg == nms_pkg::OP_BROWN) begin
                    walk_next   = walk_clamped;
                    sample_next = walk_clamped;
                end else begin
                    sample_next = crackle_sample;
                end
                state_next = nms_pkg::B_GAIN;
            end
            nms_pkg::B_GAIN: begin
                prod_next  = PROD_W'(sample_reg) * $signed(PROD_W'(cfg.gain));
                state_next = nms_pkg::B_OUT;
            end
            nms_pkg::B_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = out_scaled;
                    state_next     = nms_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = nms_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= nms_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            band_reg      <= '{default: '0};
            cnt_reg       <= '0;
            walk_reg      <= '0;
            held_reg      <= '0;
            hold_cnt_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            band_reg      <= band_next;
            cnt_reg       <= cnt_next;
            walk_reg      <= walk_next;
            held_reg      <= held_next;
            hold_cnt_reg  <= hold_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        w0_reg       <= w0_next;
        part_reg     <= part_next;
        ofs_reg      <= ofs_next;
        mul_reg      <= mul_next;
        prod_reg     <= prod_next;
        sample_reg   <= sample_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_noise_out = out_data_reg;

endmodule

// ===== src/nms_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nms_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [nms_pkg::OUT_W-1:0]  m_noise_out,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [nms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [nms_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic       gen_on_reg, gen_on_next;
    logic [2:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        gen_on_next = gen_on_reg;
        if (cfg_valid && cfg_ready && cfg_index == nms_pkg::CFG_GEN_ON) begin
            gen_on_next = cfg_data[0];
        end
        pend_next = pend_reg + 3'(in_acc) - 3'(out_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_on_reg <= 1'b0;
            pend_reg   <= '0;
        end else begin
            gen_on_reg <= gen_on_next;
            pend_reg   <= pend_next;
        end
    end

    // a word only leaves after one was taken in
    `NMS_ASSERT_IMP(a_out_has_source, aclk, aresetn, m_valid, pend_reg != 3'd0)
    // disabled block delivers silence
    `NMS_ASSERT_IMP(a_off_is_silent, aclk, aresetn, m_valid && !gen_on_reg, m_noise_out == '0)
    `NMS_ASSERT_NXT(a_out_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_noise_out))
    `NMS_ASSERT_IMP(a_quiet_after_reset, aclk, aresetn, $past(!aresetn), !m_valid)

endmodule

bind multi_mode_noise_source_top nms_checker u_nms_checker (.*);

// ===== bench/multi_mode_noise_source_top_tb.sv =====
`timescale 1ns / 1ps

module multi_mode_noise_source_top_tb;
    import nms_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_WORDS  = 1400;
    localparam int HOLD_OFF_LEN  = 300;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef logic [UNIFORM_N-1:0][UNIFORM_W-1:0] uniform_set_t;

    class noise_tracker;
        bit                  gen_on;
        logic [MODE_W-1:0]   mode;
        logic [GAIN_W-1:0]   gain;
        logic [PERIOD_W-1:0] period;
        longint              bands[PINK_SRC_N];
        logic [6:0]          band_cnt;
        longint              walk;
        longint              held;
        logic [15:0]         hold_cnt;
        logic signed [OUT_W-1:0] samples_due[$];
        int                  mismatches;

        function new();
            gen_on = 1'b0;
            mode = MODE_WHITE;
            gain = GAIN_RST;
            period = PERIOD_RST;
            foreach (bands[i]) bands[i] = 0;
            band_cnt = '0;
            walk = 0;
            held = 0;
            hold_cnt = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GEN_ON: gen_on = data[0];
                CFG_MODE:   mode = data[MODE_W-1:0];
                CFG_GAIN:   gain = data;
                CFG_PERIOD: period = data;
                default: ;
            endcase
        endfunction

        function longint white(logic [UNIFORM_W-1:0] u);
            return longint'(u) - 32768;
        endfunction

        function longint clamp16(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        function void take_word(uniform_set_t u);
            longint smp;
            longint acc;
            longint k;
            logic [6:0] nxt;
            logic [6:0] flips;
            smp = 0;
            if (gen_on) begin
                case (mode)
                    MODE_WHITE: smp = white(u[0]);
                    MODE_PINK: begin
                        nxt = band_cnt + 7'd1;
                        flips = band_cnt ^ nxt;
                        band_cnt = nxt;
                        acc = white(u[0]);
                        for (int i = 0; i < PINK_SRC_N; i++) begin
                            if (flips[i])
                                bands[i] = white(u[1 + i]);
                            acc += bands[i];
                        end
                        smp = acc >>> 3;
                    end
                    MODE_BROWN: begin
                        walk = clamp16(walk + ((white(u[0]) * 1311) >>> 16));
                        smp = walk;
                    end
                    MODE_CRACKLE: begin
                        if (u[0] >= THR_LOUD)
                            k = longint'(COEF_LOUD);
                        else if (u[0] >= THR_LIGHT)
                            k = longint'(COEF_LIGHT);
                        else
                            k = longint'(COEF_QUIET);
                        smp = (white(u[1]) * k) >>> 15;
                    end
                    MODE_HOLD: begin
                        hold_cnt = hold_cnt + 16'd1;
                        if (hold_cnt >= period) begin
                            hold_cnt = '0;
                            held = white(u[0]);
                        end
                        smp = held;
                    end
                    default: smp = 0;
                endcase
            end
            smp = clamp16((smp * longint'(gain)) >>> 15);
            samples_due.push_back(smp[OUT_W-1:0]);
        endfunction

        function void check_sample(logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            if (samples_due.size() == 0) begin
                $display("%0t: unexpected noise word, actual %0d", $time, got);
                mismatches++;
            end else begin
                want = samples_due.pop_front();
                if (got !== want) begin
                    $display("%0t: noise_out mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [UNIFORM_W-1:0] s_uniform_0, s_uniform_1, s_uniform_2, s_uniform_3;
    logic [UNIFORM_W-1:0] s_uniform_4, s_uniform_5, s_uniform_6, s_uniform_7;
    logic m_valid;
    logic m_ready;
    logic signed [OUT_W-1:0] m_noise_out;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    noise_tracker tracker;
    bit no_idle;
    bit hold_off_req;
    int cycles = 0;

    multi_mode_noise_source_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_uniform_0(s_uniform_0),
        .s_uniform_1(s_uniform_1),
        .s_uniform_2(s_uniform_2),
        .s_uniform_3(s_uniform_3),
        .s_uniform_4(s_uniform_4),
        .s_uniform_5(s_uniform_5),
        .s_uniform_6(s_uniform_6),
        .s_uniform_7(s_uniform_7),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_noise_out(m_noise_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic uniform_set_t draw_uniforms(logic [MODE_W-1:0] md, bit up);
        uniform_set_t u;
        int r;
        for (int i = 0; i < UNIFORM_N; i++) begin
            r = $urandom_range(9);
            if (r == 0)
                u[i] = '0;
            else if (r == 1)
                u[i] = '1;
            else
                u[i] = 16'($urandom);
        end
        if (md == MODE_CRACKLE && $urandom_range(2) == 0)
            u[0] = 16'($urandom_range(64800, 65535));
        // push the walk towards one rail
        if (md == MODE_BROWN && $urandom_range(9) < 7)
            u[0] = up ? 16'($urandom_range(40000, 65535)) : 16'($urandom_range(0, 25535));
        return u;
    endfunction

    // called just after a falling edge, returns just after one
    task automatic send_word(uniform_set_t u);
        while (!no_idle && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_uniform_0 <= u[0];
        s_uniform_1 <= u[1];
        s_uniform_2 <= u[2];
        s_uniform_3 <= u[3];
        s_uniform_4 <= u[4];
        s_uniform_5 <= u[5];
        s_uniform_6 <= u[6];
        s_uniform_7 <= u[7];
        do @(posedge aclk); while (!s_ready);
        tracker.take_word(u);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic configure(bit gen, logic [MODE_W-1:0] md, logic [GAIN_W-1:0] gain,
                             logic [PERIOD_W-1:0] period);
        s_valid <= 1'b0;
        while (tracker.samples_due.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        write_reg(CFG_GEN_ON, {15'd0, gen});
        write_reg(CFG_MODE, {13'd0, md});
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_PERIOD, period);
        cfg_valid <= 1'b0;
    endtask

    // receiving side, with its own hold-off counter
    initial begin
        int stall_left;
        bit hold_seen;
        stall_left = 0;
        hold_seen = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (hold_off_req != hold_seen) begin
                hold_seen = hold_off_req;
                stall_left = HOLD_OFF_LEN;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= 12);
            end
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1)
                tracker.check_sample(m_noise_out);
        end
    end

    initial begin
        uniform_set_t d;
        int sent;
        int phase;
        int len;
        int r;
        bit gen;
        bit up;
        logic [MODE_W-1:0] md;
        logic [GAIN_W-1:0] gain;
        logic [PERIOD_W-1:0] period;

        tracker = new();
        no_idle = 1'b0;
        hold_off_req = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        {s_uniform_0, s_uniform_1, s_uniform_2, s_uniform_3} = '0;
        {s_uniform_4, s_uniform_5, s_uniform_6, s_uniform_7} = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GEN_ON;
        cfg_data = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // disabled after reset
        send_word({UNIFORM_N{16'h0000}});
        send_word({UNIFORM_N{16'hFFFF}});

        configure(1'b1, MODE_WHITE, GAIN_RST, PERIOD_RST);
        send_word({UNIFORM_N{16'h0000}});
        send_word({UNIFORM_N{16'hFFFF}});
        send_word({UNIFORM_N{16'h8000}});

        // gain above unity saturates
        configure(1'b1, MODE_WHITE, 16'hFFFF, 16'd1);
        send_word({UNIFORM_N{16'h0000}});
        send_word({UNIFORM_N{16'hFFFF}});

        configure(1'b1, MODE_PINK, 16'd0, 16'd1);
        send_word(draw_uniforms(MODE_PINK, 1'b0));
        send_word(draw_uniforms(MODE_PINK, 1'b0));

        configure(1'b1, MODE_BROWN, GAIN_RST, 16'd1);
        send_word({UNIFORM_N{16'hFFFF}});
        send_word({UNIFORM_N{16'h0000}});

        configure(1'b1, MODE_CRACKLE, GAIN_RST, 16'd1);
        d = {UNIFORM_N{16'hFFFF}};
        d[0] = THR_LOUD;
        send_word(d);
        d[0] = THR_LOUD - 16'd1;
        send_word(d);
        d[0] = THR_LIGHT;
        d[1] = 16'h0000;
        send_word(d);
        d[0] = THR_LIGHT - 16'd1;
        send_word(d);
        d[0] = 16'h0000;
        d[1] = 16'hFFFF;
        send_word(d);

        // zero period takes a new value on every word
        configure(1'b1, MODE_HOLD, GAIN_RST, 16'd0);
        send_word(draw_uniforms(MODE_HOLD, 1'b0));
        send_word(draw_uniforms(MODE_HOLD, 1'b0));

        // period lowered below the running count
        configure(1'b1, MODE_HOLD, GAIN_RST, 16'hFFFF);
        repeat (3) send_word(draw_uniforms(MODE_HOLD, 1'b0));
        configure(1'b1, MODE_HOLD, GAIN_RST, 16'd1);
        send_word(draw_uniforms(MODE_HOLD, 1'b0));

        configure(1'b1, MODE_SPARE_LO, GAIN_RST, PERIOD_RST);
        send_word(draw_uniforms(MODE_WHITE, 1'b0));
        configure(1'b1, MODE_SPARE_HI, GAIN_RST, PERIOD_RST);
        send_word(draw_uniforms(MODE_WHITE, 1'b0));
        configure(1'b0, MODE_PINK, GAIN_RST, PERIOD_RST);
        send_word(draw_uniforms(MODE_PINK, 1'b0));

        sent = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            gen = ($urandom_range(9) != 0);
            r = $urandom_range(19);
            md = (r < 18) ? 3'(r % 5) : 3'($urandom_range(5, 7));
            case ($urandom_range(5))
                0: gain = 16'd0;
                1: gain = GAIN_RST;
                2: gain = 16'hFFFF;
                3: gain = 16'($urandom_range(32769, 65535));
                default: gain = 16'($urandom_range(0, 32768));
            endcase
            case ($urandom_range(3))
                0: period = 16'd1;
                1: period = 16'hFFFF;
                default: period = 16'($urandom_range(1, 20));
            endcase
            up = 1'($urandom_range(1));
            len = $urandom_range(20, 80);
            configure(gen, md, gain, period);
            if (phase == 3) begin
                hold_off_req = !hold_off_req;
                len = 80;
            end
            if (phase == 6) begin
                no_idle = 1'b1;
                len = 150;
            end
            repeat (len) send_word(draw_uniforms(md, up));
            no_idle = 1'b0;
            sent += len;
            phase++;
        end

        s_valid <= 1'b0;
        while (tracker.samples_due.size() != 0)
            @(negedge aclk);
        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/nms_pkg.sv
src/nms_front.sv
src/nms_queue.sv
src/nms_back.sv
src/multi_mode_noise_source_top.sv
src/nms_checker.sv
bench/multi_mode_noise_source_top_tb.sv
